// ===== sv/prqs_pkg.sv =====
`default_nettype none
package prqs_pkg;
  localparam int NUM_TASKS_DEF = 16;
  localparam int NUM_PRIOS_DEF = 32;
  localparam int ACT_W = 3;
  localparam int ID_W = 4;
  localparam int PRIO_W = 5;
  localparam int LOCK_W = 8;
  localparam logic [LOCK_W-1:0] LOCK_MAX = 8'd255;

  typedef enum logic [ACT_W-1:0] {
    ACT_READY    = 3'd0,
    ACT_UNREADY  = 3'd1,
    ACT_SCHEDULE = 3'd2,
    ACT_LOCK     = 3'd3,
    ACT_UNLOCK   = 3'd4,
    ACT_YIELD    = 3'd5
  } action_t;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ID_W-1:0]   task_id;
    logic [PRIO_W-1:0] task_prio;
  } in_word_t;

  typedef struct packed {
    logic              switch_now;
    logic [ID_W-1:0]   active_task;
    logic [PRIO_W-1:0] top_prio;
    logic              none_ready;
    logic [LOCK_W-1:0] lock_depth;
    logic              op_error;
  } out_word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RM_HEAD,
    ST_WALK,
    ST_APPEND,
    ST_SCHED,
    ST_YIELD_PICK,
    ST_RESULT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic set_err;
    logic do_append;
    logic do_rm_head;
    logic do_walk;
    logic do_sched;
    logic do_yield_pick;
    logic do_lock;
    logic do_unlock;
    logic do_result;
    logic yield_mode;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic arg_ok;
    logic queued;
    logic prio_match;
    logic self_ok;
    logic self_is_tail;
    logic is_head;
    logic walk_done;
    logic lock_one;
  } dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/prqs_ctrl.sv =====
`default_nettype none
module prqs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire prqs_pkg::dp_stat_t stat,
  output prqs_pkg::dp_cmd_t      cmd
);
  import prqs_pkg::*;

  state_t state_r, state_nxt;
  logic   yield_r, yield_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      yield_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      yield_r <= yield_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    yield_nxt = yield_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DECODE;
          yield_nxt = 1'b0;
        end
      end
      ST_DECODE: begin
        yield_nxt = 1'b0;
        priority case (stat.action)
          ACT_READY: state_nxt = (stat.arg_ok && !stat.queued) ? ST_APPEND : ST_RESULT;
          ACT_UNREADY: state_nxt = (stat.arg_ok && stat.queued && stat.prio_match) ?
                                   ST_RM_HEAD : ST_RESULT;
          ACT_SCHEDULE: state_nxt = ST_SCHED;
          ACT_LOCK: state_nxt = ST_RESULT;
          ACT_UNLOCK: state_nxt = stat.lock_one ? ST_SCHED : ST_RESULT;
          ACT_YIELD: begin
            if (stat.self_ok && !stat.self_is_tail) begin
              state_nxt = ST_RM_HEAD;
              yield_nxt = 1'b1;
            end else begin
              state_nxt = ST_RESULT;
            end
          end
          default: state_nxt = ST_RESULT;
        endcase
      end
      ST_RM_HEAD: state_nxt = stat.is_head ? (yield_r ? ST_APPEND : ST_RESULT) : ST_WALK;
      ST_WALK: if (stat.walk_done) state_nxt = yield_r ? ST_APPEND : ST_RESULT;
      ST_APPEND: state_nxt = yield_r ? ST_YIELD_PICK : ST_RESULT;
      ST_SCHED: state_nxt = ST_RESULT;
      ST_YIELD_PICK: state_nxt = ST_RESULT;
      ST_RESULT: state_nxt = ST_OUT;
      ST_OUT: if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.yield_mode = yield_r;
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_OUT);
    unique case (state_r)
      ST_IDLE: cmd.load = in_valid;
      ST_DECODE: begin
        priority case (stat.action)
          ACT_READY: cmd.set_err = !(stat.arg_ok && !stat.queued);
          ACT_UNREADY: cmd.set_err = !(stat.arg_ok && stat.queued && stat.prio_match);
          ACT_LOCK: cmd.do_lock = 1'b1;
          ACT_UNLOCK: cmd.do_unlock = 1'b1;
          ACT_YIELD: cmd.set_err = !stat.self_ok;
          ACT_SCHEDULE: cmd.set_err = 1'b0;
          default: cmd.set_err = 1'b1;
        endcase
      end
      ST_RM_HEAD: cmd.do_rm_head = 1'b1;
      ST_WALK: cmd.do_walk = 1'b1;
      ST_APPEND: cmd.do_append = 1'b1;
      ST_SCHED: cmd.do_sched = 1'b1;
      ST_YIELD_PICK: cmd.do_yield_pick = 1'b1;
      ST_RESULT: cmd.do_result = 1'b1;
      ST_OUT: cmd.load = 1'b0;
      default: cmd.load = 1'b0;
    endcase
  end

`ifndef SYNTHESIS
  a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == ST_OUT) else $error("out_valid outside output state");
  a_result_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RESULT |=> state_r == ST_OUT) else $error("result not presented");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped under stall");
`endif
endmodule
`default_nettype wire

// ===== sv/prqs_dp.sv =====
`default_nettype none
module prqs_dp #(
  parameter int NUM_TASKS = prqs_pkg::NUM_TASKS_DEF,
  parameter int NUM_PRIOS = prqs_pkg::NUM_PRIOS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire prqs_pkg::in_word_t in_data,
  input  wire prqs_pkg::dp_cmd_t  cmd,
  output prqs_pkg::dp_stat_t      stat,
  output prqs_pkg::out_word_t     out_data
);
  import prqs_pkg::*;

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PW = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
  localparam int NG = (NUM_PRIOS + 7) / 8;
  localparam int GW = (NG > 1) ? $clog2(NG) : 1;

  logic [TW-1:0] link_r [NUM_TASKS];
  logic [TW-1:0] head_r [NUM_PRIOS];
  logic [TW-1:0] tail_r [NUM_PRIOS];
  logic [PW-1:0] prio_of_r [NUM_TASKS];
  logic [NUM_PRIOS-1:0] ready_r;
  logic [NUM_TASKS-1:0] queued_r;
  logic [TW-1:0]  cur_r;
  logic           cur_valid_r;
  logic [LOCK_W-1:0] lock_r;

  in_word_t      req_r;
  logic          err_r, sw_r;
  logic [TW-1:0] id_r, walk_r;
  logic [PW-1:0] p_r;
  out_word_t     out_r;

  // top priority search over the bit map
  logic [PW-1:0] top;
  logic          any;
  always_comb begin
    top = '0;
    any = 1'b0;
    for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
      if (ready_r[i]) begin
        top = PW'(i);
        any = 1'b1;
      end
    end
  end

  logic arg_ok, in_task_ok;
  logic [TW-1:0] rid;
  logic [PW-1:0] rprio;
  always_comb begin
    arg_ok = (32'(req_r.task_id) < NUM_TASKS) && (32'(req_r.task_prio) < NUM_PRIOS);
    rid = TW'(req_r.task_id);
    rprio = PW'(req_r.task_prio);
    in_task_ok = (32'(cur_r) < NUM_TASKS);
  end

  logic [TW-1:0] walk_nx;
  assign walk_nx = link_r[walk_r];

  assign stat.action = req_r.action;
  assign stat.arg_ok = arg_ok;
  assign stat.queued = queued_r[rid];
  assign stat.prio_match = (prio_of_r[rid] == rprio);
  assign stat.self_ok = cur_valid_r && in_task_ok && queued_r[cur_r];
  assign stat.self_is_tail = (tail_r[prio_of_r[cur_r]] == cur_r);
  assign stat.is_head = (head_r[p_r] == id_r);
  assign stat.walk_done = (walk_r == tail_r[p_r]) || (walk_nx == id_r);
  assign stat.lock_one = (lock_r == LOCK_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r <= '0;
      queued_r <= '0;
      cur_r <= '0;
      cur_valid_r <= 1'b0;
      lock_r <= '0;
      err_r <= 1'b0;
      sw_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        req_r <= in_data;
        err_r <= 1'b0;
        sw_r <= 1'b0;
      end
      if (cmd.set_err) err_r <= 1'b1;
      // latch the queue under work
      if (cmd.load) begin
        id_r <= TW'(in_data.task_id);
        p_r <= PW'(in_data.task_prio);
      end
      if (cmd.yield_mode == 1'b0 && cmd.do_rm_head == 1'b0 && cmd.do_walk == 1'b0 &&
          cmd.load == 1'b0 && cmd.do_append == 1'b0 && req_r.action == ACT_YIELD) begin
        id_r <= cur_r;
        p_r <= prio_of_r[cur_r];
      end
      if (cmd.do_lock && lock_r != LOCK_MAX) lock_r <= lock_r + LOCK_W'(1);
      if (cmd.do_unlock && lock_r != '0) lock_r <= lock_r - LOCK_W'(1);
      if (cmd.do_rm_head) begin
        walk_r <= head_r[p_r];
        if (head_r[p_r] == id_r) begin
          if (tail_r[p_r] == id_r) ready_r[p_r] <= 1'b0;
          else head_r[p_r] <= link_r[id_r];
        end
        if (!cmd.yield_mode) queued_r[id_r] <= 1'b0;
      end
      if (cmd.do_walk) begin
        if (walk_r != tail_r[p_r]) begin
          if (walk_nx == id_r) begin
            link_r[walk_r] <= link_r[id_r];
            if (tail_r[p_r] == id_r) tail_r[p_r] <= walk_r;
          end else begin
            walk_r <= walk_nx;
          end
        end
      end
      if (cmd.do_append) begin
        if (ready_r[p_r]) link_r[tail_r[p_r]] <= id_r;
        else head_r[p_r] <= id_r;
        tail_r[p_r] <= id_r;
        ready_r[p_r] <= 1'b1;
        queued_r[id_r] <= 1'b1;
        prio_of_r[id_r] <= p_r;
      end
      if (cmd.do_sched && lock_r == '0 && any) begin
        if (!cur_valid_r || head_r[top] != cur_r) begin
          cur_r <= head_r[top];
          cur_valid_r <= 1'b1;
          sw_r <= 1'b1;
        end
      end
      if (cmd.do_yield_pick && head_r[p_r] != cur_r) begin
        cur_r <= head_r[p_r];
        sw_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_result) begin
      out_r.switch_now <= sw_r;
      out_r.active_task <= cur_valid_r ? ID_W'(cur_r) : '0;
      out_r.top_prio <= any ? PRIO_W'(top) : '0;
      out_r.none_ready <= !any;
      out_r.lock_depth <= lock_r;
      out_r.op_error <= err_r;
    end
  end
  assign out_data = out_r;

`ifndef SYNTHESIS
  a_sw_has_cur: assert property (@(posedge clk) disable iff (!rst_n)
    sw_r |-> cur_valid_r) else $error("switch without current task");
  a_map_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (queued_r == '0) |-> !cmd.do_walk) else $error("walk on empty map");
  a_lock_sat: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(lock_r) == LOCK_MAX && $past(cmd.do_lock)) |-> lock_r == LOCK_MAX)
    else $error("lock count wrapped");
`endif
endmodule
`default_nettype wire

// ===== sv/priority_ready_queue_scheduler.sv =====
`default_nettype none
// flow: accept, decode, then list work, result and output; unready and yield
// walk the priority list one link per cycle, other actions skip the walk
// throughput: one word at a time; the next word is taken the cycle after the result leaves
// reset: synchronous active-low rst_n clears map, queued flags, current task and lock
// count; list links are don't-care until written
module priority_ready_queue_scheduler #(
  parameter int NUM_TASKS = prqs_pkg::NUM_TASKS_DEF,
  parameter int NUM_PRIOS = prqs_pkg::NUM_PRIOS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire prqs_pkg::in_word_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output prqs_pkg::out_word_t     out_data
);
  import prqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  prqs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  prqs_dp #(.NUM_TASKS(NUM_TASKS), .NUM_PRIOS(NUM_PRIOS)) u_dp (
    .clk, .rst_n, .in_data, .cmd, .stat, .out_data
  );
endmodule
`default_nettype wire

// ===== sim/priority_ready_queue_scheduler_tb.sv =====
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_tb;
  import prqs_pkg::*;

  localparam int NT = NUM_TASKS_DEF;
  localparam int NP = NUM_PRIOS_DEF;
  localparam int RANDOM_WORDS = 1110;
  // action codes outside the defined set
  localparam logic [ACT_W-1:0] ACT_BAD_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_BAD_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  priority_ready_queue_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler shadow state
  logic [ID_W-1:0] nxt_link [NT];
  logic [ID_W-1:0] fifo_head [NP];
  logic [ID_W-1:0] fifo_tail [NP];
  logic [NP-1:0] prio_busy;
  logic [NT-1:0] in_fifo;
  logic [PRIO_W-1:0] task_level [NT];
  logic [ID_W-1:0] run_task;
  logic run_valid;
  logic [LOCK_W-1:0] lock_cnt;

  out_word_t sched_q[$];
  int errors = 0;
  int words_out = 0;
  int switches = 0;
  int fills = 0;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;

  function automatic void shadow_reset();
    prio_busy = '0;
    in_fifo = '0;
    run_task = '0;
    run_valid = 1'b0;
    lock_cnt = '0;
    for (int i = 0; i < NT; i++) begin
      nxt_link[i] = '0;
      task_level[i] = '0;
    end
    for (int i = 0; i < NP; i++) begin
      fifo_head[i] = '0;
      fifo_tail[i] = '0;
    end
  endfunction

  function automatic void fifo_push(int p, logic [ID_W-1:0] id);
    if (prio_busy[p]) nxt_link[fifo_tail[p]] = id;
    else fifo_head[p] = id;
    fifo_tail[p] = id;
    prio_busy[p] = 1'b1;
  endfunction

  function automatic void fifo_drop(int p, logic [ID_W-1:0] id);
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] nx;
    if (fifo_head[p] == id) begin
      if (fifo_tail[p] == id) prio_busy[p] = 1'b0;
      else fifo_head[p] = nxt_link[id];
      return;
    end
    cur = fifo_head[p];
    for (int n = 0; n < NT; n++) begin
      if (cur == fifo_tail[p]) return;
      nx = nxt_link[cur];
      if (nx == id) begin
        nxt_link[cur] = nxt_link[id];
        if (fifo_tail[p] == id) fifo_tail[p] = cur;
        return;
      end
      cur = nx;
    end
  endfunction

  function automatic int top_level();
    for (int p = 0; p < NP; p++)
      if (prio_busy[p]) return p;
    return -1;
  endfunction

  function automatic bit dispatch();
    int p;
    p = top_level();
    if (lock_cnt != 0 || p < 0) return 1'b0;
    if (!run_valid || fifo_head[p] != run_task) begin
      run_task = fifo_head[p];
      run_valid = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t sched_step(in_word_t w);
    out_word_t r;
    bit sw;
    bit err;
    int p;
    sw = 1'b0;
    err = 1'b0;
    case (w.action)
      ACT_READY: begin
        if (in_fifo[w.task_id]) err = 1'b1;
        else begin
          fifo_push(w.task_prio, w.task_id);
          in_fifo[w.task_id] = 1'b1;
          task_level[w.task_id] = w.task_prio;
        end
      end
      ACT_UNREADY: begin
        if (!in_fifo[w.task_id] || task_level[w.task_id] != w.task_prio) err = 1'b1;
        else begin
          fifo_drop(w.task_prio, w.task_id);
          in_fifo[w.task_id] = 1'b0;
        end
      end
      ACT_SCHEDULE: sw = dispatch();
      ACT_LOCK: if (lock_cnt != LOCK_MAX) lock_cnt++;
      ACT_UNLOCK: begin
        if (lock_cnt != 0) begin
          lock_cnt--;
          if (lock_cnt == 0) sw = dispatch();
        end
      end
      ACT_YIELD: begin
        if (!run_valid || !in_fifo[run_task]) err = 1'b1;
        else begin
          p = task_level[run_task];
          if (fifo_tail[p] != run_task) begin
            fifo_drop(p, run_task);
            fifo_push(p, run_task);
            if (fifo_head[p] != run_task) begin
              run_task = fifo_head[p];
              sw = 1'b1;
            end
          end
        end
      end
      default: err = 1'b1;
    endcase
    p = top_level();
    r.switch_now = sw;
    r.active_task = run_valid ? run_task : '0;
    r.top_prio = (p < 0) ? '0 : PRIO_W'(p);
    r.none_ready = (p < 0);
    r.lock_depth = lock_cnt;
    r.op_error = err;
    return r;
  endfunction

  // directed rows; chk set where the result is typed in
  typedef struct {
    in_word_t w;
    bit chk;
    out_word_t r;
  } row_t;
  row_t rows[$];

  function automatic in_word_t mk(logic [ACT_W-1:0] a, int id, int p);
    in_word_t w;
    w.action = a;
    w.task_id = ID_W'(id);
    w.task_prio = PRIO_W'(p);
    return w;
  endfunction

  function automatic out_word_t res(bit sw, int t, int p, bit nr, int lk, bit e);
    out_word_t r;
    r.switch_now = sw;
    r.active_task = ID_W'(t);
    r.top_prio = PRIO_W'(p);
    r.none_ready = nr;
    r.lock_depth = LOCK_W'(lk);
    r.op_error = e;
    return r;
  endfunction

  function automatic void add(in_word_t w, bit chk = 0, out_word_t r = '0);
    row_t x;
    x.w = w;
    x.chk = chk;
    x.r = r;
    rows.push_back(x);
  endfunction

  task automatic send(in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 17);
      in_valid <= 1'b0;
      in_data <= '0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    int k;
    w.task_id = ID_W'($urandom_range(0, NT - 1));
    // few priorities so fifos get deep, sometimes anywhere in range
    w.task_prio = ($urandom_range(0, 3) == 0) ? PRIO_W'($urandom_range(0, NP - 1))
                                              : PRIO_W'($urandom_range(0, 3) * 9);
    k = $urandom_range(0, 99);
    if (k < 30) w.action = ACT_READY;
    else if (k < 45) begin
      w.action = ACT_UNREADY;
      // mostly a matching priority so removal actually happens
      if ($urandom_range(0, 3) != 0) w.task_prio = task_level[w.task_id];
    end
    else if (k < 65) w.action = ACT_SCHEDULE;
    else if (k < 72) w.action = ACT_LOCK;
    else if (k < 80) w.action = ACT_UNLOCK;
    else if (k < 97) w.action = ACT_YIELD;
    else w.action = ($urandom_range(0, 1) != 0) ? ACT_BAD_LO : ACT_BAD_HI;
    return w;
  endfunction

  initial begin
    in_word_t w;
    out_word_t r;
    shadow_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add(mk(ACT_SCHEDULE, 0, 0), 1, res(0, 0, 0, 1, 0, 0));
    add(mk(ACT_YIELD, 0, 0), 1, res(0, 0, 0, 1, 0, 1));
    add(mk(ACT_UNREADY, 3, 4), 1, res(0, 0, 0, 1, 0, 1));
    add(mk(ACT_UNLOCK, 0, 0), 1, res(0, 0, 0, 1, 0, 0));
    add(mk(ACT_BAD_LO, 0, 0), 1, res(0, 0, 0, 1, 0, 1));
    add(mk(ACT_BAD_HI, 15, 31), 1, res(0, 0, 0, 1, 0, 1));
    add(mk(ACT_READY, 15, 31), 1, res(0, 0, 31, 0, 0, 0));
    add(mk(ACT_READY, 15, 31), 1, res(0, 0, 31, 0, 0, 1));
    add(mk(ACT_SCHEDULE, 0, 0), 1, res(1, 15, 31, 0, 0, 0));
    add(mk(ACT_YIELD, 0, 0));
    add(mk(ACT_READY, 0, 31));
    add(mk(ACT_READY, 7, 31));
    add(mk(ACT_YIELD, 0, 0));
    add(mk(ACT_READY, 5, 0));
    add(mk(ACT_LOCK, 0, 0));
    add(mk(ACT_SCHEDULE, 0, 0));
    add(mk(ACT_UNLOCK, 0, 0));
    add(mk(ACT_UNREADY, 5, 1));
    add(mk(ACT_UNREADY, 5, 0));
    add(mk(ACT_UNREADY, 0, 31));
    add(mk(ACT_SCHEDULE, 0, 0));
    add(mk(ACT_YIELD, 0, 0));
    add(mk(ACT_UNREADY, 15, 31));
    add(mk(ACT_UNREADY, 7, 31));
    add(mk(ACT_SCHEDULE, 0, 0));
    foreach (rows[i]) begin
      r = sched_step(rows[i].w);
      if (rows[i].chk && r != rows[i].r) begin
        $error("row %0d: table %h, predictor %h", i, rows[i].r, r);
        errors++;
      end
      sched_q.push_back(rows[i].chk ? rows[i].r : r);
      send(rows[i].w);
    end

    // lock saturation, then back to zero
    for (int i = 0; i < 300; i++) begin
      w = mk((i < 257) ? ACT_LOCK : ACT_UNLOCK, 0, 0);
      if (i == 298) w = mk(ACT_SCHEDULE, 0, 0);
      sched_q.push_back(sched_step(w));
      send(w);
      sender_gap();
    end
    while (lock_cnt != 0) begin
      w = mk(ACT_UNLOCK, 0, 0);
      sched_q.push_back(sched_step(w));
      send(w);
    end

    // fill everything so the receiver hold-off backs the block up
    hold_long = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 200) hold_long = 1'b0;
      if (i == RANDOM_WORDS - 200) quiet = 1'b1;
      w = rand_word();
      if (in_fifo == '0) fills++;
      sched_q.push_back(sched_step(w));
      send(w);
      sender_gap();
    end
    in_valid <= 1'b0;
    in_data <= '0;
    while (sched_q.size() != 0) @(posedge clk);
    repeat (NT + 10) @(posedge clk);
    $display("covered %0d results, %0d task switches, lock saturation, %0d empty-map passes",
             words_out, switches, fills);
    if (errors == 0 && sched_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // receiver stalls, with one long hold-off early in the random part
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (150) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_long);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      words_out++;
      if (sched_q.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        errors++;
      end else begin
        e = sched_q.pop_front();
        if (out_data.switch_now) switches++;
        if (out_data.switch_now !== e.switch_now) begin
          $error("switch_now exp %0d got %0d", e.switch_now, out_data.switch_now);
          errors++;
        end
        if (out_data.active_task !== e.active_task) begin
          $error("active_task exp %0d got %0d", e.active_task, out_data.active_task);
          errors++;
        end
        if (out_data.top_prio !== e.top_prio) begin
          $error("top_prio exp %0d got %0d", e.top_prio, out_data.top_prio);
          errors++;
        end
        if (out_data.none_ready !== e.none_ready) begin
          $error("none_ready exp %0d got %0d", e.none_ready, out_data.none_ready);
          errors++;
        end
        if (out_data.lock_depth !== e.lock_depth) begin
          $error("lock_depth exp %0d got %0d", e.lock_depth, out_data.lock_depth);
          errors++;
        end
        if (out_data.op_error !== e.op_error) begin
          $error("op_error exp %0d got %0d", e.op_error, out_data.op_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
